// File: hw/rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and codes for the cartridge bank mapper: access opcodes,
// result targets, mapper kinds, register indexes and the banking state.
// ----------------------------------------------------------------------------
package cbm_pkg;

   localparam int unsigned OPCODE_W    = 2;
   localparam int unsigned ADDRESS_W   = 16;
   localparam int unsigned VALUE_W     = 8;
   localparam int unsigned TARGET_W    = 2;
   localparam int unsigned MEM_ADDR_W  = 23;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned ROM_BANK_W  = 9;
   localparam int unsigned RAM_BANK_W  = 8;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   // bank sizes: 16 KiB ROM banks, 8 KiB RAM banks
   localparam int unsigned ROM_BANK_BYTES = 16384;
   localparam int unsigned RAM_BANK_BYTES = 8192;
   localparam int unsigned ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
   localparam int unsigned RAM_OFS_W      = $clog2(RAM_BANK_BYTES);

   // access opcodes
   localparam logic [OPCODE_W-1:0] OP_CTRL_WRITE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ROM_READ   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RAM_READ   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_RAM_WRITE  = 2'd3;

   // result targets
   localparam logic [TARGET_W-1:0] TGT_NONE = 2'd0;
   localparam logic [TARGET_W-1:0] TGT_ROM  = 2'd1;
   localparam logic [TARGET_W-1:0] TGT_RAM  = 2'd2;

   // mapper kinds
   localparam logic [KIND_W-1:0] KIND_MBC1 = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MBC3 = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MBC5 = 2'd2;

   // register indexes
   localparam logic REG_MAPPER_KIND   = 1'b0;
   localparam logic REG_ROM_BANK_MASK = 1'b1;

   // reset values
   localparam logic [KIND_W-1:0]     MAPPER_KIND_RST   = KIND_MBC1;
   localparam logic [ROM_BANK_W-1:0] ROM_BANK_MASK_RST = 9'd127;
   localparam logic [ROM_BANK_W-1:0] ROM_BANK_RST      = 9'd1;
   localparam logic [RAM_BANK_W-1:0] RAM_BANK_RST      = 8'd0;

   // control region bounds
   localparam logic [ADDRESS_W-1:0] CTRL_RAM_EN_END   = 16'h2000;
   localparam logic [ADDRESS_W-1:0] CTRL_ROM_LO_END   = 16'h3000;
   localparam logic [ADDRESS_W-1:0] CTRL_ROM_BANK_END = 16'h4000;
   localparam logic [ADDRESS_W-1:0] CTRL_RAM_BANK_END = 16'h6000;

   localparam logic [3:0]         RAM_EN_KEY    = 4'hA;
   localparam logic [VALUE_W-1:0] RAM_EN_KEY_B  = 8'h0A;
   localparam logic [RAM_BANK_W-1:0] MBC3_RAM_BANK_MAX = 8'd3;

   typedef struct packed {
      logic                  ram_enable;
      logic [ROM_BANK_W-1:0] rom_bank;
      logic [RAM_BANK_W-1:0] ram_bank;
      logic                  banking_mode;
   } bank_state_type;

   typedef struct packed {
      logic [KIND_W-1:0]     mapper_kind;
      logic [ROM_BANK_W-1:0] rom_bank_mask;
   } cfg_type;

endpackage

// File: hw/rtl/cbm_csr.sv
// ----------------------------------------------------------------------------
// cbm_csr
// APB-style configuration registers: mapper kind and ROM bank mask.
// ----------------------------------------------------------------------------
module cbm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cbm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cbm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cbm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output cbm_pkg::cfg_type               cfg
);
   import cbm_pkg::*;

   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [ROM_BANK_W-1:0] mask_ff, mask_in;
   logic                  wr_en;
   logic                  reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      kind_in = kind_ff;
      mask_in = mask_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MAPPER_KIND:   kind_in = csr_pwdata[KIND_W-1:0];
            REG_ROM_BANK_MASK: mask_in = csr_pwdata[ROM_BANK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= MAPPER_KIND_RST;
         mask_ff <= ROM_BANK_MASK_RST;
      end else begin
         kind_ff <= kind_in;
         mask_ff <= mask_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_sel)
         REG_MAPPER_KIND:   csr_prdata = {{(CSR_DATA_W-KIND_W){1'b0}}, kind_ff};
         REG_ROM_BANK_MASK: csr_prdata = {{(CSR_DATA_W-ROM_BANK_W){1'b0}}, mask_ff};
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.mapper_kind   = kind_ff;
   assign cfg.rom_bank_mask = mask_ff;

endmodule

// File: hw/rtl/cbm_bank_state.sv
// ----------------------------------------------------------------------------
// cbm_bank_state
// Banking state registers and the per-mapper control write decode.
// ----------------------------------------------------------------------------
module cbm_bank_state (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ctrl_wr,
   input  logic [cbm_pkg::ADDRESS_W-1:0] ctrl_address,
   input  logic [cbm_pkg::VALUE_W-1:0]   ctrl_value,
   input  cbm_pkg::cfg_type              cfg,
   output cbm_pkg::bank_state_type       bank
);
   import cbm_pkg::*;

   bank_state_type state_ff, state_in;
   logic           in_ram_en, in_rom_lo, in_rom_bank, in_ram_bank;
   logic [4:0]     mbc1_lo;
   logic [6:0]     mbc3_lo;
   logic [1:0]     mbc1_hi;

   assign in_ram_en   = ctrl_address < CTRL_RAM_EN_END;
   assign in_rom_lo   = ctrl_address < CTRL_ROM_LO_END;
   assign in_rom_bank = ctrl_address < CTRL_ROM_BANK_END;
   assign in_ram_bank = ctrl_address < CTRL_RAM_BANK_END;

   // zero bank select maps to bank one
   assign mbc1_lo = (ctrl_value[4:0] == 5'd0) ? 5'd1 : ctrl_value[4:0];
   assign mbc3_lo = (ctrl_value[6:0] == 7'd0) ? 7'd1 : ctrl_value[6:0];
   assign mbc1_hi = ctrl_value[1:0];

   always_comb begin
      state_in = state_ff;
      if (ctrl_wr) begin
         case (cfg.mapper_kind)
            KIND_MBC1: begin
               if (in_ram_en) begin
                  state_in.ram_enable = ctrl_value[3:0] == RAM_EN_KEY;
               end else if (in_rom_bank) begin
                  state_in.rom_bank = {1'b0, state_ff.rom_bank[7:5], mbc1_lo};
               end else if (in_ram_bank) begin
                  if (state_ff.banking_mode) begin
                     state_in.ram_bank = {6'd0, mbc1_hi};
                  end else begin
                     state_in.rom_bank = {2'b00, mbc1_hi, state_ff.rom_bank[4:0]}
                                         & cfg.rom_bank_mask;
                  end
               end else begin
                  state_in.banking_mode = ctrl_value[0];
               end
            end
            KIND_MBC3: begin
               if (in_ram_en) begin
                  state_in.ram_enable = ctrl_value[3:0] == RAM_EN_KEY;
               end else if (in_rom_bank) begin
                  state_in.rom_bank = {2'b00, mbc3_lo};
               end else if (in_ram_bank) begin
                  state_in.ram_bank = ctrl_value;
               end
            end
            KIND_MBC5: begin
               if (in_ram_en) begin
                  state_in.ram_enable = ctrl_value == RAM_EN_KEY_B;
               end else if (in_rom_lo) begin
                  state_in.rom_bank = {state_ff.rom_bank[8], ctrl_value};
               end else if (in_rom_bank) begin
                  state_in.rom_bank = {ctrl_value[0], state_ff.rom_bank[7:0]};
               end else if (in_ram_bank) begin
                  state_in.ram_bank = {state_ff.ram_bank[7:4], ctrl_value[3:0]};
               end
            end
            default: ;  // unknown kind ignores control writes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.ram_enable   <= 1'b0;
         state_ff.rom_bank     <= ROM_BANK_RST;
         state_ff.ram_bank     <= RAM_BANK_RST;
         state_ff.banking_mode <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign bank = state_ff;

endmodule

// File: hw/rtl/cbm_result_stage.sv
// ----------------------------------------------------------------------------
// cbm_result_stage
// Physical address mapping for one access and the result register.
// ----------------------------------------------------------------------------
module cbm_result_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cbm_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [cbm_pkg::ADDRESS_W-1:0]  req_address,
   input  logic [cbm_pkg::VALUE_W-1:0]    req_value,
   input  cbm_pkg::bank_state_type        bank,
   input  cbm_pkg::cfg_type               cfg,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cbm_pkg::TARGET_W-1:0]   rsp_target,
   output logic [cbm_pkg::MEM_ADDR_W-1:0] rsp_mem_address,
   output logic                           rsp_mem_write,
   output logic [cbm_pkg::VALUE_W-1:0]    rsp_write_data
);
   import cbm_pkg::*;

   logic                  valid_ff, valid_in;
   logic [TARGET_W-1:0]   target_ff, target_in;
   logic [MEM_ADDR_W-1:0] addr_ff, addr_in;
   logic                  write_ff, write_in;
   logic [VALUE_W-1:0]    data_ff, data_in;
   logic                  accept;
   logic                  ram_mapped;

   assign req_ready = ~valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   assign ram_mapped = bank.ram_enable &
                       ~((cfg.mapper_kind == KIND_MBC3) & (bank.ram_bank > MBC3_RAM_BANK_MAX));

   always_comb begin
      target_in = TGT_NONE;
      addr_in   = '0;
      write_in  = 1'b0;
      data_in   = '0;
      case (req_opcode)
         OP_CTRL_WRITE: ;
         OP_ROM_READ: begin
            target_in = TGT_ROM;
            addr_in   = {bank.rom_bank, req_address[ROM_OFS_W-1:0]};
         end
         OP_RAM_READ, OP_RAM_WRITE: begin
            if (ram_mapped) begin
               target_in = TGT_RAM;
               addr_in   = {{(MEM_ADDR_W-RAM_BANK_W-RAM_OFS_W){1'b0}},
                            bank.ram_bank, req_address[RAM_OFS_W-1:0]};
               if (req_opcode == OP_RAM_WRITE) begin
                  write_in = 1'b1;
                  data_in  = req_value;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         target_ff <= target_in;
         addr_ff   <= addr_in;
         write_ff  <= write_in;
         data_ff   <= data_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_target      = target_ff;
   assign rsp_mem_address = addr_ff;
   assign rsp_mem_write   = write_ff;
   assign rsp_write_data  = data_ff;

endmodule

// File: hw/rtl/cartridge_bank_mapper_unit.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_unit
// The result is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle; a held result stalls the input in the same cycle.
// A control write updates the banking state at its acceptance edge, so the
// next request sees it. Synchronous reset restores the banking state and configuration
// registers to reset values and clears the result valid; the payload is not reset.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cbm_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [cbm_pkg::ADDRESS_W-1:0]  req_address,
   input  logic [cbm_pkg::VALUE_W-1:0]    req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cbm_pkg::TARGET_W-1:0]   rsp_target,
   output logic [cbm_pkg::MEM_ADDR_W-1:0] rsp_mem_address,
   output logic                           rsp_mem_write,
   output logic [cbm_pkg::VALUE_W-1:0]    rsp_write_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cbm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cbm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cbm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import cbm_pkg::*;

   cfg_type        cfg;
   bank_state_type bank;
   logic           ctrl_wr;

   assign ctrl_wr = req_valid & req_ready & (req_opcode == OP_CTRL_WRITE);

   cbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cbm_bank_state u_bank_state (
      .clock        (clock),
      .reset        (reset),
      .ctrl_wr      (ctrl_wr),
      .ctrl_address (req_address),
      .ctrl_value   (req_value),
      .cfg          (cfg),
      .bank         (bank)
   );

   cbm_result_stage u_result_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_address     (req_address),
      .req_value       (req_value),
      .bank            (bank),
      .cfg             (cfg),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_target      (rsp_target),
      .rsp_mem_address (rsp_mem_address),
      .rsp_mem_write   (rsp_mem_write),
      .rsp_write_data  (rsp_write_data)
   );

endmodule

// File: dv/cartridge_bank_mapper_unit_tb.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_unit_tb
// Self-checking bench for the cartridge bank mapper. Reset-value checks and
// directed MBC1, MBC3, MBC5 and unused-kind cases come first, then random
// bus traffic under several mapper settings, with random stalls on both
// channels, one long result hold-off and a final stretch at full rate. Every
// result is checked against a mirror of the banking state kept in the bench.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cbm_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [TARGET_W-1:0]   target;
      logic [MEM_ADDR_W-1:0] mem_address;
      logic                  mem_write;
      logic [VALUE_W-1:0]    write_data;
   } mapping_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [OPCODE_W-1:0]   req_opcode;
   logic [ADDRESS_W-1:0]  req_address;
   logic [VALUE_W-1:0]    req_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [TARGET_W-1:0]   rsp_target;
   logic [MEM_ADDR_W-1:0] rsp_mem_address;
   logic                  rsp_mem_write;
   logic [VALUE_W-1:0]    rsp_write_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // mirror of the mapper configuration and banking state
   logic [KIND_W-1:0]     kind_q;
   logic [ROM_BANK_W-1:0] mask_q;
   bank_state_type        bank_q;

   mapping_type expected_accesses[$];
   mapping_type want_access;

   int  mismatch_count = 0;
   int  request_count  = 0;
   int  rom_count      = 0;
   int  ram_count      = 0;
   int  ram_write_count = 0;
   int  none_count     = 0;
   int  setting_count  = 0;
   int  held_cycles    = 0;
   int  hold_request   = 0;
   bit  idling_on      = 1'b1;

   cartridge_bank_mapper_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_address     (req_address),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_target      (rsp_target),
      .rsp_mem_address (rsp_mem_address),
      .rsp_mem_write   (rsp_mem_write),
      .rsp_write_data  (rsp_write_data),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endfunction

   // control write into the banking state mirror
   function automatic void apply_bank_write(input logic [ADDRESS_W-1:0] addr,
                                            input logic [VALUE_W-1:0] val);
      logic [4:0] low5;
      logic [6:0] low7;
      case (kind_q)
         KIND_MBC1: begin
            if (addr < CTRL_RAM_EN_END) begin
               bank_q.ram_enable = (val[3:0] == RAM_EN_KEY);
            end else if (addr < CTRL_ROM_BANK_END) begin
               // zero in the low five bits selects bank one, bit 8 drops
               low5 = (val[4:0] == 5'd0) ? 5'd1 : val[4:0];
               bank_q.rom_bank = {1'b0, bank_q.rom_bank[7:5], low5};
            end else if (addr < CTRL_RAM_BANK_END) begin
               if (bank_q.banking_mode) begin
                  bank_q.ram_bank = {6'd0, val[1:0]};
               end else begin
                  bank_q.rom_bank = {2'b00, val[1:0], bank_q.rom_bank[4:0]} & mask_q;
               end
            end else begin
               bank_q.banking_mode = val[0];
            end
         end
         KIND_MBC3: begin
            if (addr < CTRL_RAM_EN_END) begin
               bank_q.ram_enable = (val[3:0] == RAM_EN_KEY);
            end else if (addr < CTRL_ROM_BANK_END) begin
               low7 = (val[6:0] == 7'd0) ? 7'd1 : val[6:0];
               bank_q.rom_bank = {2'b00, low7};
            end else if (addr < CTRL_RAM_BANK_END) begin
               bank_q.ram_bank = val;
            end
         end
         KIND_MBC5: begin
            if (addr < CTRL_RAM_EN_END) begin
               bank_q.ram_enable = (val == RAM_EN_KEY_B);
            end else if (addr < CTRL_ROM_LO_END) begin
               bank_q.rom_bank = {bank_q.rom_bank[8], val};
            end else if (addr < CTRL_ROM_BANK_END) begin
               bank_q.rom_bank = {val[0], bank_q.rom_bank[7:0]};
            end else if (addr < CTRL_RAM_BANK_END) begin
               bank_q.ram_bank = {bank_q.ram_bank[7:4], val[3:0]};
            end
         end
         // the fourth kind ignores control writes
         default: ;
      endcase
   endfunction

   function automatic mapping_type map_access(input logic [OPCODE_W-1:0] op,
                                              input logic [ADDRESS_W-1:0] addr,
                                              input logic [VALUE_W-1:0] val);
      mapping_type r;
      r = '0;
      request_count++;
      if (op == OP_CTRL_WRITE) begin
         apply_bank_write(addr, val);
      end else if (op == OP_ROM_READ) begin
         r.target      = TGT_ROM;
         r.mem_address = {bank_q.rom_bank, addr[ROM_OFS_W-1:0]};
      end else if (bank_q.ram_enable &&
                   !(kind_q == KIND_MBC3 && bank_q.ram_bank > MBC3_RAM_BANK_MAX)) begin
         r.target      = TGT_RAM;
         r.mem_address = {2'b00, bank_q.ram_bank, addr[RAM_OFS_W-1:0]};
         if (op == OP_RAM_WRITE) begin
            r.mem_write  = 1'b1;
            r.write_data = val;
         end
      end
      case (r.target)
         TGT_ROM: rom_count++;
         TGT_RAM: begin
            ram_count++;
            if (r.mem_write) begin
               ram_write_count++;
            end
         end
         default: none_count++;
      endcase
      return r;
   endfunction

   task automatic send_request(input logic [OPCODE_W-1:0] op,
                               input logic [ADDRESS_W-1:0] addr,
                               input logic [VALUE_W-1:0] val);
      int gap;
      @(negedge clock);
      req_valid   = 1'b1;
      req_opcode  = op;
      req_address = addr;
      req_value   = val;
      do @(posedge clock); while (!req_ready);
      expected_accesses.push_back(map_access(op, addr, val));
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_random_request();
      logic [OPCODE_W-1:0]  op;
      logic [ADDRESS_W-1:0] addr;
      logic [VALUE_W-1:0]   val;
      int                   pick;
      pick = $urandom_range(0, 9);
      addr = ADDRESS_W'($urandom);
      val  = VALUE_W'($urandom);
      if (pick < 3) begin
         op = OP_CTRL_WRITE;
         case ($urandom_range(0, 3))
            0: begin
               addr = ADDRESS_W'($urandom_range(0, 16'h1FFF));
               // mostly the enable key so that RAM requests get through
               if ($urandom_range(0, 3) != 0) begin
                  val = $urandom_range(0, 1) ? RAM_EN_KEY_B : {val[7:4], RAM_EN_KEY};
               end
            end
            1: addr = ADDRESS_W'($urandom_range(16'h2000, 16'h3FFF));
            2: begin
               addr = ADDRESS_W'($urandom_range(16'h4000, 16'h5FFF));
               if ($urandom_range(0, 3) != 0) begin
                  val = VALUE_W'($urandom_range(0, 3));
               end
            end
            default: addr = ADDRESS_W'($urandom_range(16'h6000, 16'hFFFF));
         endcase
      end else if (pick < 5) begin
         op = OP_ROM_READ;
      end else if (pick < 8) begin
         op = OP_RAM_READ;
      end else begin
         op = OP_RAM_WRITE;
      end
      send_request(op, addr, val);
   endtask

   // drop valid and let every outstanding result arrive
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_accesses.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic check_register(input logic idx, input logic [CSR_DATA_W-1:0] want);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = {idx, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         note_mismatch($sformatf("register %0d read expected %h, got %h",
                                 idx, want, csr_prdata));
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic write_register(input logic idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_MAPPER_KIND) begin
         kind_q = data[KIND_W-1:0];
      end else begin
         mask_q = data[ROM_BANK_W-1:0];
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      check_register(idx, data);
   endtask

   task automatic set_mapper(input logic [KIND_W-1:0] kind,
                             input logic [ROM_BANK_W-1:0] mask);
      wait_for_results();
      write_register(REG_MAPPER_KIND, CSR_DATA_W'(kind));
      write_register(REG_ROM_BANK_MASK, CSR_DATA_W'(mask));
      setting_count++;
   endtask

   task automatic test_reset_state();
      check_register(REG_MAPPER_KIND, CSR_DATA_W'(MAPPER_KIND_RST));
      check_register(REG_ROM_BANK_MASK, CSR_DATA_W'(ROM_BANK_MASK_RST));
      send_request(OP_ROM_READ, 16'h0000, 8'h00);
      send_request(OP_RAM_READ, 16'hFFFF, 8'h00);
      send_request(OP_RAM_WRITE, 16'h1FFF, 8'hFF);
   endtask

   task automatic test_mbc1_rules();
      send_request(OP_CTRL_WRITE, 16'h0000, 8'h1A);
      send_request(OP_RAM_WRITE, 16'hFFFF, 8'hFF);
      send_request(OP_CTRL_WRITE, 16'h2000, 8'h00);
      send_request(OP_CTRL_WRITE, 16'h3FFF, 8'h5F);
      // upper bank bits in ROM mode, cut by the bank mask
      send_request(OP_CTRL_WRITE, 16'h4000, 8'hFF);
      send_request(OP_ROM_READ, 16'hFFFF, 8'h00);
      send_request(OP_CTRL_WRITE, 16'h6000, 8'hFF);
      send_request(OP_CTRL_WRITE, 16'h5FFF, 8'h02);
      send_request(OP_RAM_READ, 16'h1234, 8'h00);
      send_request(OP_CTRL_WRITE, 16'hFFFF, 8'hFE);
   endtask

   task automatic test_mbc3_rules();
      set_mapper(KIND_MBC3, 9'd511);
      send_request(OP_CTRL_WRITE, 16'h2000, 8'h80);
      send_request(OP_CTRL_WRITE, 16'h3FFF, 8'hFF);
      send_request(OP_CTRL_WRITE, 16'h4000, 8'h04);
      send_request(OP_RAM_READ, 16'h0000, 8'h00);
      send_request(OP_CTRL_WRITE, 16'h5FFF, 8'h03);
      send_request(OP_CTRL_WRITE, 16'h6000, 8'h55);
      send_request(OP_RAM_WRITE, 16'hE000, 8'h5A);
   endtask

   task automatic test_mbc5_rules();
      set_mapper(KIND_MBC5, 9'd511);
      send_request(OP_CTRL_WRITE, 16'h0000, 8'h1A);
      send_request(OP_RAM_READ, 16'h0001, 8'h00);
      send_request(OP_CTRL_WRITE, 16'h1FFF, 8'h0A);
      send_request(OP_CTRL_WRITE, 16'h2FFF, 8'hFF);
      send_request(OP_CTRL_WRITE, 16'h3000, 8'h01);
      send_request(OP_CTRL_WRITE, 16'h4000, 8'hFF);
      send_request(OP_CTRL_WRITE, 16'h6000, 8'h00);
      send_request(OP_ROM_READ, 16'hFFFF, 8'h00);
   endtask

   task automatic test_unused_kind();
      set_mapper(KIND_UNUSED, 9'd0);
      send_request(OP_CTRL_WRITE, 16'h0000, 8'h00);
      send_request(OP_RAM_READ, 16'h0ABC, 8'h00);
      send_request(OP_ROM_READ, 16'h2345, 8'h00);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: set_mapper(KIND_MBC1, 9'd127);
            1: set_mapper(KIND_MBC1, 9'd1);
            2: set_mapper(KIND_MBC1, 9'd511);
            3: set_mapper(KIND_MBC3, 9'd511);
            4: set_mapper(KIND_MBC3, 9'd0);
            5: set_mapper(KIND_MBC5, 9'd511);
            6: set_mapper(KIND_MBC5, 9'd1);
            7: set_mapper(KIND_UNUSED, ROM_BANK_W'($urandom));
            default: set_mapper(KIND_W'($urandom_range(0, 3)),
                                ROM_BANK_W'($urandom_range(1, 511)));
         endcase
         repeat (100) send_random_request();
      end
   endtask

   task automatic test_backpressure();
      set_mapper(KIND_MBC1, ROM_BANK_W'($urandom_range(1, 511)));
      idling_on    = 1'b0;
      hold_request = 200;
      repeat (60) send_random_request();
      idling_on    = 1'b1;
   endtask

   task automatic test_full_rate();
      set_mapper(KIND_W'($urandom_range(0, 2)), ROM_BANK_W'($urandom_range(1, 511)));
      idling_on = 1'b0;
      repeat (150) send_random_request();
   endtask

   // result side: random stall bursts, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_ready = 1'b0;
            while (hold_request > 0) begin
               @(negedge clock);
               hold_request--;
               held_cycles++;
            end
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_accesses.size() == 0) begin
            note_mismatch($sformatf("result with nothing expected: target %0d address %h",
                                    rsp_target, rsp_mem_address));
         end else begin
            want_access = expected_accesses.pop_front();
            if (rsp_target !== want_access.target ||
                rsp_mem_address !== want_access.mem_address ||
                rsp_mem_write !== want_access.mem_write ||
                rsp_write_data !== want_access.write_data) begin
               note_mismatch($sformatf(
                  "expected target %0d addr %h wr %b data %h, got target %0d addr %h wr %b data %h",
                  want_access.target, want_access.mem_address, want_access.mem_write,
                  want_access.write_data, rsp_target, rsp_mem_address, rsp_mem_write,
                  rsp_write_data));
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", expected_accesses.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = OP_CTRL_WRITE;
      req_address = '0;
      req_value   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      kind_q      = MAPPER_KIND_RST;
      mask_q      = ROM_BANK_MASK_RST;
      bank_q      = '0;
      bank_q.rom_bank = ROM_BANK_RST;
      bank_q.ram_bank = RAM_BANK_RST;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_mbc1_rules();
      test_mbc3_rules();
      test_mbc5_rules();
      test_unused_kind();
      test_random_traffic();
      test_backpressure();
      test_full_rate();
      wait_for_results();
      repeat (5) @(posedge clock);

      $display("%0d requests mapped: %0d to ROM, %0d to RAM (%0d writes), %0d with no target",
               request_count, rom_count, ram_count, ram_write_count, none_count);
      $display("%0d mapper settings, result side held off for %0d cycles, %0d mismatches",
               setting_count, held_cycles, mismatch_count);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
